// ===== src/efc_pkg.sv =====
// efc_pkg: shared types and constants for the event fragment counter.
// Used by efc_cell, efc_table, the top level and the checker; no dependencies.
`default_nettype none

package efc_pkg;

    // Fixed field widths
    localparam int unsigned EvIdBits   = 32;
    localparam int unsigned CountBits  = 6;
    localparam int unsigned PartsBits  = 7;
    localparam int unsigned NumSrcBits = 7;

    // Source count limits and reset value
    localparam logic [NumSrcBits-1:0] MaxSources   = 7'd64;
    localparam logic [NumSrcBits-1:0] ResetSources = 7'd3;

    // Outcome of one fragment
    typedef enum logic [1:0] {
        ST_NEW      = 2'd0,
        ST_COUNTED  = 2'd1,
        ST_COMPLETE = 2'd2,
        ST_DROPPED  = 2'd3
    } t_status;

    // Per-entry update command
    typedef struct packed {
        logic alloc;
        logic incr;
        logic clear;
    } t_cell_ctl;

    // Result of one lookup
    typedef struct packed {
        t_status                status;
        logic [PartsBits-1:0]   parts;
    } t_result;

endpackage

`default_nettype wire

// ===== src/efc_cell.sv =====
// efc_cell: one table entry holding valid flag, event identifier and count.
// Depends on efc_pkg for the update command struct and count width.
`default_nettype none

module efc_cell import efc_pkg::*; #(
    parameter int unsigned KEY_BITS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [KEY_BITS-1:0]  i_key,
    input  wire t_cell_ctl            i_ctl,
    input  wire logic [CountBits-1:0] i_new_count,
    output logic                      o_match,
    output logic                      o_free,
    output logic [CountBits-1:0]      o_count
);

    logic                 r_valid;
    logic [KEY_BITS-1:0]  r_id;
    logic [CountBits-1:0] r_count;

    // Occupancy: set on allocation, drop on completion
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.alloc) begin
            r_valid <= 1'b1;
        end else if (i_ctl.clear) begin
            r_valid <= 1'b0;
        end
    end

    // Identifier and count; only read while the entry is valid
    always_ff @(posedge i_clk) begin
        if (i_ctl.alloc) begin
            r_id    <= i_key;
            r_count <= CountBits'(1);
        end else if (i_ctl.incr) begin
            r_count <= i_new_count;
        end
    end

    // Compare against the incoming identifier
    assign o_match = r_valid && (r_id == i_key);
    assign o_free  = !r_valid;
    assign o_count = r_count;

endmodule

`default_nettype wire

// ===== src/efc_table.sv =====
// efc_table: row of entries with parallel compare, lowest-free pick and update decision.
// Depends on efc_pkg and efc_cell.
`default_nettype none

module efc_table import efc_pkg::*; #(
    parameter int unsigned ENTRIES  = 64,
    parameter int unsigned KEY_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    input  wire logic [KEY_BITS-1:0]   i_key,
    input  wire logic [NumSrcBits-1:0] i_target,
    output t_result                    o_result
);

    logic [ENTRIES-1:0]   match_vec;
    logic [ENTRIES-1:0]   free_vec;
    logic [ENTRIES-1:0]   free_pick;
    logic [CountBits-1:0] count_vec [ENTRIES];
    logic [CountBits-1:0] count_sel;
    logic [PartsBits-1:0] parts_next;
    t_cell_ctl            ctl_vec   [ENTRIES];
    logic                 hit;
    logic                 any_free;
    logic                 done;
    logic                 single;

    // Entries
    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        efc_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_key       (i_key),
            .i_ctl       (ctl_vec[g]),
            .i_new_count (parts_next[CountBits-1:0]),
            .o_match     (match_vec[g]),
            .o_free      (free_vec[g]),
            .o_count     (count_vec[g])
        );
    end

    // Select the count of the matching entry (identifiers are unique)
    always_comb begin
        count_sel = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (match_vec[i]) begin
                count_sel = count_sel | count_vec[i];
            end
        end
    end

    // Isolate the lowest free entry
    assign free_pick  = free_vec & (~free_vec + ENTRIES'(1));
    assign any_free   = |free_vec;
    assign hit        = |match_vec;
    assign parts_next = {1'b0, count_sel} + PartsBits'(1);
    assign done       = parts_next >= i_target;
    assign single     = i_target == NumSrcBits'(1);

    // Per-entry commands
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            ctl_vec[i].clear = i_valid && match_vec[i] && done;
            ctl_vec[i].incr  = i_valid && match_vec[i] && !done;
            ctl_vec[i].alloc = i_valid && !hit && !single && free_pick[i];
        end
    end

    // Outcome for the item
    always_comb begin
        if (hit) begin
            o_result.status = done ? ST_COMPLETE : ST_COUNTED;
            o_result.parts  = parts_next;
        end else if (single) begin
            o_result.status = ST_COMPLETE;
            o_result.parts  = PartsBits'(1);
        end else if (any_free) begin
            o_result.status = ST_NEW;
            o_result.parts  = PartsBits'(1);
        end else begin
            o_result.status = ST_DROPPED;
            o_result.parts  = '0;
        end
    end

endmodule

`default_nettype wire

// ===== src/event_fragment_counter_unit.sv =====
// Event fragment counter: each item passes the input register, then the result register;
// the strobe marks a loaded result; one item may be taken every cycle, set by a single
// pass of parallel compare and lowest-free pick over the entry row.
// Synchronous active-low reset clears all entry valid bits and the pipeline valid bits and
// sets the source count to 3; busy is high during reset. The receiver cannot stall.
// Depends on efc_pkg and efc_table.
`default_nettype none

module event_fragment_counter_unit import efc_pkg::*; #(
    parameter int unsigned TABLE_ENTRIES = 64,
    parameter int unsigned ID_BITS       = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [EvIdBits-1:0]   i_event_id,
    input  wire logic                  i_cfg_we,
    input  wire logic [NumSrcBits-1:0] i_cfg_wdata,
    output logic                       o_strobe,
    output logic [EvIdBits-1:0]        o_event_id_out,
    output logic [1:0]                 o_status,
    output logic [PartsBits-1:0]       o_parts_seen
);

    localparam int unsigned KeyBits = (ID_BITS < EvIdBits) ? ID_BITS : EvIdBits;

    logic                  r_live;
    logic [NumSrcBits-1:0] r_num_sources;
    logic                  r_in_valid;
    logic [EvIdBits-1:0]   r_in_id;
    logic                  r_out_valid;
    logic [EvIdBits-1:0]   r_out_id;
    t_status               r_status;
    logic [PartsBits-1:0]  r_parts;
    logic [NumSrcBits-1:0] target;
    logic [KeyBits-1:0]    key;
    logic                  accept;
    t_result               result;

    // Ready once out of reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= 1'b0;
        end else begin
            r_live <= 1'b1;
        end
    end

    assign busy   = !r_live;
    assign accept = start && !busy;

    // Source count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_sources <= ResetSources;
        end else if (i_cfg_we) begin
            r_num_sources <= i_cfg_wdata;
        end
    end

    // Clamp the target to one..MaxSources
    always_comb begin
        if (r_num_sources == '0) begin
            target = NumSrcBits'(1);
        end else if (r_num_sources > MaxSources) begin
            target = MaxSources;
        end else begin
            target = r_num_sources;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_id <= i_event_id;
        end
    end

    assign key = r_in_id[KeyBits-1:0];

    // Lookup and table update
    efc_table #(
        .ENTRIES  (TABLE_ENTRIES),
        .KEY_BITS (KeyBits)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_in_valid),
        .i_key    (key),
        .i_target (target),
        .o_result (result)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_out_id <= EvIdBits'(key);
            r_status <= result.status;
            r_parts  <= result.parts;
        end
    end

    assign o_strobe       = r_out_valid;
    assign o_event_id_out = r_out_id;
    assign o_status       = r_status;
    assign o_parts_seen   = r_parts;

endmodule

`default_nettype wire

// ===== src/efc_checker.sv =====
// efc_checker: port-level checks for the event fragment counter, bound to the top level.
// Depends on efc_pkg and event_fragment_counter_unit.
`default_nettype none

module efc_checker import efc_pkg::*; #(
    parameter int unsigned ID_BITS = 32
) (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  start,
    input wire logic                  busy,
    input wire logic [EvIdBits-1:0]   i_event_id,
    input wire logic                  o_strobe,
    input wire logic [EvIdBits-1:0]   o_event_id_out,
    input wire logic [1:0]            o_status,
    input wire logic [PartsBits-1:0]  o_parts_seen
);

    localparam logic [EvIdBits-1:0] IdMask =
        (ID_BITS >= EvIdBits) ? {EvIdBits{1'b1}} : EvIdBits'((64'd1 << ID_BITS) - 64'd1);

    // Every item taken gives a result
    a_item_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_strobe)
        else $error("accepted item gave no result");

    // A result only follows a taken item
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 2))
        else $error("result without accepted item");

    // The identifier is echoed, cut to the key width
    a_id_echo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_event_id_out == ($past(i_event_id, 2) & IdMask)))
        else $error("identifier not echoed");

    // Opened or dropped entries carry a fixed fragment count
    a_parts_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ST_NEW)) |-> (o_parts_seen == PartsBits'(1)))
        else $error("new entry count is not one");

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ST_DROPPED)) |-> (o_parts_seen == '0))
        else $error("dropped item has nonzero count");

endmodule

bind event_fragment_counter_unit efc_checker #(
    .ID_BITS (ID_BITS)
) u_efc_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .i_event_id     (i_event_id),
    .o_strobe       (o_strobe),
    .o_event_id_out (o_event_id_out),
    .o_status       (o_status),
    .o_parts_seen   (o_parts_seen)
);

`default_nettype wire
